@@ rtl/krat_pkg.sv @@
// Shared types and constants for the keyed running average table.
// Field widths, mode and outcome codes, controller command and status structs.
// Used by every file of the block except krat_ram.
package krat_pkg;

    localparam int LVL_W   = 7;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 16;
    localparam int MODE_W  = 3;
    localparam int MAT_FW  = 4;
    localparam int DIR_FW  = 2;
    localparam int SLOT_FW = 4;
    localparam int OUTC_W  = 2;

    // Blend numerator level*count + new and divisor count + 1.
    localparam int NUM_W = LVL_W + CNT_W;
    localparam int DEN_W = CNT_W + 1;

    // Entry word: {updated flag, key, level}.
    localparam int ENT_W = 1 + KEY_W + LVL_W;

    localparam logic [LVL_W-1:0] ABSENT_RESET = 7'd99;

    localparam logic [MODE_W-1:0] MODE_SAMPLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE_DIR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE_SRV = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

    localparam logic [OUTC_W-1:0] OUTC_MATCHED  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_INSERTED = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_DROPPED  = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_DONE     = 2'd3;

    typedef enum logic [2:0] {
        KIND_BAD_MODE,
        KIND_BAD_ADDR,
        KIND_FULL,
        KIND_DONE,
        KIND_MATCH,
        KIND_INSERT,
        KIND_ENTRY
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      clr_step;
        logic      cnt_load;
        logic      cnt_bump;
        logic      k_clear;
        logic      k_slot;
        logic      k_inc;
        logic      scan_check;
        logic      take_free;
        logic      entry_latch;
        logic      mul;
        logic      div_start;
        logic      write_sample;
        logic      write_close;
        logic      write_load;
        logic      read_result;
        logic      emit;
        res_kind_t kind;
    } krat_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              mode_bad;
        logic              addr_bad;
        logic              clr_last;
        logic              last_slot;
        logic              key_hit;
        logic              free_seen;
        logic              div_done;
        logic              out_busy;
    } krat_status_t;

endpackage

@@ rtl/krat_in_if.sv @@
// Request channel of the keyed running average table.
// Valid/ready handshake with the request fields; depends on krat_pkg.
interface krat_in_if
    import krat_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [MAT_FW-1:0]  matrix;
    logic [DIR_FW-1:0]  direction;
    logic [SLOT_FW-1:0] slot;
    logic [LVL_W-1:0]   level;
    logic [KEY_W-1:0]   label_key;

    modport source (output valid, mode, matrix, direction, slot, level, label_key,
                    input ready);
    modport sink (input valid, mode, matrix, direction, slot, level, label_key,
                  output ready);
endinterface

@@ rtl/krat_out_if.sv @@
// Result channel of the keyed running average table.
// Valid/ready handshake with the result fields; depends on krat_pkg.
interface krat_out_if
    import krat_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SLOT_FW-1:0] hit_slot;
    logic [OUTC_W-1:0]  outcome;
    logic [LVL_W-1:0]   new_level;
    logic [KEY_W-1:0]   slot_key;
    logic [CNT_W-1:0]   survey_count;

    modport source (output valid, hit_slot, outcome, new_level, slot_key, survey_count,
                    input ready);
    modport sink (input valid, hit_slot, outcome, new_level, slot_key, survey_count,
                  output ready);
endinterface

@@ rtl/keyed_running_average_table.sv @@
// Keyed running average table: MATRICES fingerprint tables of DIRECTIONS
// headings by SLOTS slots, each slot a key, a 7-bit level and an updated flag,
// with a survey count per table, all in single-port-read RAMs. After reset a
// clearing pass over all MATRICES*DIRECTIONS*SLOTS entries (640 by default)
// fills the stores; no request is taken meanwhile, configuration writes are.
// Requests are handled one at a time. A sample scans the slots with a
// registered RAM read per slot, then runs a bit-serial divide; a direction
// close reads, multiplies and divides per slot. The next request is taken
// while the previous result waits in the output register.
module keyed_running_average_table
    import krat_pkg::*;
#(
    parameter int MATRICES   = 16,
    parameter int DIRECTIONS = 4,
    parameter int SLOTS      = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LVL_W-1:0] cfg_wr_data,
    krat_in_if.sink          item,
    krat_out_if.source       result
);
    krat_cmd_t    cmd;
    krat_status_t st;

    krat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    krat_dp #(
        .MATRICES   (MATRICES),
        .DIRECTIONS (DIRECTIONS),
        .SLOTS      (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_mode      (item.mode),
        .in_matrix    (item.matrix),
        .in_direction (item.direction),
        .in_slot      (item.slot),
        .in_level     (item.level),
        .in_label_key (item.label_key),
        .cmd          (cmd),
        .st           (st),
        .result       (result)
    );
endmodule

@@ rtl/krat_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module krat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/krat_div.sv @@
// Restoring divider for the level blend, one quotient bit per cycle.
// Quotient is known to fit in a level; depends on krat_pkg.
module krat_div
    import krat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [LVL_W-1:0] quot
);
    localparam int STEP_W = $clog2(LVL_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [DEN_W-1:0]  den_hold_reg;
    logic [LVL_W-1:0]  quot_reg;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(LVL_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= num;
            // align the divisor with the top quotient bit
            dsh_reg      <= NUM_W'({den, {(LVL_W - 1){1'b0}}});
            den_hold_reg <= den;
            quot_reg     <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[LVL_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < NUM_W'(den_hold_reg)))
        else $error("divider remainder not below divisor");
`endif
endmodule

@@ rtl/krat_ctrl.sv @@
// Sequencer of the keyed running average table: clearing pass, slot scan,
// blend, write-back and result hand-off. Depends on krat_pkg.
module krat_ctrl
    import krat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  krat_status_t st,
    output krat_cmd_t    cmd
);
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CNT,
        S_SURVEY,
        S_SCAN_ADDR,
        S_SCAN_CHK,
        S_SCAN_END,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_WRITE,
        S_CL_ADDR,
        S_CL_CHK,
        S_EN_ADDR,
        S_EN_CHK,
        S_OUT
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= KIND_DONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (st.mode_bad)
                begin
                    kind_next  = KIND_BAD_MODE;
                    state_next = S_OUT;
                end
                else if (st.addr_bad)
                begin
                    kind_next  = KIND_BAD_ADDR;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                cmd.cnt_load = 1'b1;
                priority if (st.mode == MODE_CLOSE_SRV)
                begin
                    state_next = S_SURVEY;
                end
                else if (st.mode == MODE_SAMPLE)
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = S_SCAN_ADDR;
                end
                else if (st.mode == MODE_CLOSE_DIR)
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = S_CL_ADDR;
                end
                else
                begin
                    cmd.k_slot = 1'b1;
                    state_next = S_EN_ADDR;
                end
            end
            S_SURVEY:
            begin
                cmd.cnt_bump = 1'b1;
                kind_next    = KIND_DONE;
                state_next   = S_OUT;
            end
            S_SCAN_ADDR:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_check = 1'b1;
                priority if (st.key_hit)
                begin
                    kind_next  = KIND_MATCH;
                    state_next = S_MUL;
                end
                else if (st.last_slot)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_SCAN_ADDR;
                end
            end
            S_SCAN_END:
            begin
                if (st.free_seen)
                begin
                    cmd.take_free = 1'b1;
                    kind_next     = KIND_INSERT;
                    state_next    = S_MUL;
                end
                else
                begin
                    kind_next  = KIND_FULL;
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (st.mode == MODE_CLOSE_DIR)
                begin
                    cmd.write_close = 1'b1;
                    if (st.last_slot)
                    begin
                        kind_next  = KIND_DONE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_CL_ADDR;
                    end
                end
                else
                begin
                    cmd.write_sample = 1'b1;
                    state_next       = S_OUT;
                end
            end
            S_CL_ADDR:
            begin
                state_next = S_CL_CHK;
            end
            S_CL_CHK:
            begin
                cmd.entry_latch = 1'b1;
                state_next      = S_MUL;
            end
            S_EN_ADDR:
            begin
                state_next = S_EN_CHK;
            end
            S_EN_CHK:
            begin
                if (st.mode == MODE_LOAD)
                begin
                    cmd.write_load = 1'b1;
                end
                else
                begin
                    cmd.read_result = 1'b1;
                end
                kind_next  = KIND_ENTRY;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register frees up
                if (!st.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !st.out_busy)
        else $error("result emitted over an untaken result");
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!in_ready && !cmd.write_sample && !cmd.write_load))
        else $error("request path active during clearing pass");
`endif
endmodule

@@ rtl/krat_dp.sv @@
// Datapath of the keyed running average table: entry and count RAMs, request
// registers, blend multiply, divider and result register. Depends on krat_pkg,
// krat_ram, krat_div and krat_out_if.
module krat_dp
    import krat_pkg::*;
#(
    parameter int MATRICES   = 16,
    parameter int DIRECTIONS = 4,
    parameter int SLOTS      = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LVL_W-1:0]   cfg_wr_data,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [MAT_FW-1:0]  in_matrix,
    input  logic [DIR_FW-1:0]  in_direction,
    input  logic [SLOT_FW-1:0] in_slot,
    input  logic [LVL_W-1:0]   in_level,
    input  logic [KEY_W-1:0]   in_label_key,
    input  krat_cmd_t          cmd,
    output krat_status_t       st,
    krat_out_if.source         result
);
    localparam int ENTRIES = MATRICES * DIRECTIONS * SLOTS;
    localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAT_W   = (MATRICES > 1) ? $clog2(MATRICES) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CLR_W   = $clog2(ENTRIES + 1);

    // control registers
    logic [LVL_W-1:0]  absent_reg;
    logic [CLR_W-1:0]  clr_reg;
    logic              free_seen_reg;
    logic              out_valid_reg;

    // request and work registers
    logic [MODE_W-1:0]  mode_reg;
    logic [MAT_FW-1:0]  m_reg;
    logic [DIR_FW-1:0]  d_reg;
    logic [SLOT_FW-1:0] s_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ENTRY_W-1:0] base_reg;
    logic [SLOT_W-1:0]  k_reg;
    logic [SLOT_W-1:0]  free_idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LVL_W-1:0]   old_reg;
    logic [KEY_W-1:0]   ekey_reg;
    logic               eflag_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [LVL_W-1:0]   res_level_reg;
    logic [KEY_W-1:0]   res_key_reg;

    // output register
    logic [SLOT_FW-1:0] o_hit_reg;
    logic [OUTC_W-1:0]  o_outc_reg;
    logic [LVL_W-1:0]   o_level_reg;
    logic [KEY_W-1:0]   o_key_reg;
    logic [CNT_W-1:0]   o_cnt_reg;

    logic               ent_we;
    logic [ENTRY_W-1:0] ent_waddr;
    logic [ENT_W-1:0]   ent_wdata;
    logic [ENTRY_W-1:0] ent_addr;
    logic [ENT_W-1:0]   ent_rdata;
    logic [LVL_W-1:0]   rd_level;
    logic [KEY_W-1:0]   rd_key;
    logic               rd_flag;

    logic               cnt_we;
    logic [MAT_W-1:0]   cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [CNT_W-1:0]   cnt_sat;
    logic [MAT_W-1:0]   m_idx;

    logic               div_done;
    logic [LVL_W-1:0]   quot;
    logic [LVL_W-1:0]   add_lvl;
    logic               rd_free;

    assign m_idx    = MAT_W'(m_reg);
    assign ent_addr = base_reg + ENTRY_W'(k_reg);
    assign rd_level = ent_rdata[LVL_W-1:0];
    assign rd_key   = ent_rdata[LVL_W+KEY_W-1:LVL_W];
    assign rd_flag  = ent_rdata[ENT_W-1];
    assign rd_free  = (rd_level == absent_reg);
    assign cnt_sat  = (cnt_reg == '1) ? cnt_reg : cnt_reg + CNT_W'(1);
    // closing a direction pulls stale slots toward the absent level
    assign add_lvl  = (mode_reg == MODE_CLOSE_DIR) ? absent_reg : lvl_reg;

    krat_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_addr),
        .rdata (ent_rdata)
    );

    krat_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MATRICES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (m_idx),
        .rdata (cnt_rdata)
    );

    krat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = ent_addr;
        ent_wdata = {1'b0, {KEY_W{1'b0}}, ABSENT_RESET};
        priority if (cmd.clr_step)
        begin
            ent_we    = 1'b1;
            ent_waddr = clr_reg[ENTRY_W-1:0];
        end
        else if (cmd.write_sample)
        begin
            ent_we    = 1'b1;
            ent_wdata = {1'b1, key_reg, quot};
        end
        else if (cmd.write_close)
        begin
            ent_we    = 1'b1;
            ent_wdata = {1'b0, ekey_reg, eflag_reg ? old_reg : quot};
        end
        else if (cmd.write_load)
        begin
            ent_we    = 1'b1;
            ent_wdata = {rd_flag, key_reg, lvl_reg};
        end
        else
        begin
            ent_we = 1'b0;
        end
    end

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = m_idx;
        cnt_wdata = cnt_sat;
        priority if (cmd.clr_step)
        begin
            cnt_we    = (clr_reg < CLR_W'(MATRICES));
            cnt_waddr = clr_reg[MAT_W-1:0];
            cnt_wdata = '0;
        end
        else if (cmd.cnt_bump)
        begin
            cnt_we = 1'b1;
        end
        else
        begin
            cnt_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            absent_reg    <= ABSENT_RESET;
            clr_reg       <= '0;
            free_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                absent_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (cmd.k_clear)
            begin
                free_seen_reg <= 1'b0;
            end
            else if (cmd.scan_check && rd_free)
            begin
                free_seen_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            m_reg    <= in_matrix;
            d_reg    <= in_direction;
            s_reg    <= in_slot;
            lvl_reg  <= in_level;
            key_reg  <= in_label_key;
            base_reg <= ENTRY_W'((int'(in_matrix) * DIRECTIONS + int'(in_direction))
                                 * SLOTS);
        end
        if (cmd.cnt_load)
        begin
            cnt_reg <= cnt_rdata;
        end
        else if (cmd.cnt_bump)
        begin
            cnt_reg <= cnt_sat;
        end
        priority if (cmd.k_clear)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_slot)
        begin
            k_reg <= SLOT_W'(s_reg);
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + SLOT_W'(1);
        end
        else if (cmd.take_free)
        begin
            k_reg <= free_idx_reg;
        end
        // remember only the first free slot of the scan
        if (cmd.scan_check && rd_free && !free_seen_reg)
        begin
            free_idx_reg <= k_reg;
        end
        priority if (cmd.take_free)
        begin
            old_reg <= absent_reg;
        end
        else if (cmd.scan_check || cmd.entry_latch)
        begin
            old_reg <= rd_level;
        end
        if (cmd.entry_latch)
        begin
            ekey_reg  <= rd_key;
            eflag_reg <= rd_flag;
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(old_reg) * NUM_W'(cnt_reg) + NUM_W'(add_lvl);
            den_reg <= DEN_W'(cnt_reg) + DEN_W'(1);
        end
        priority if (cmd.write_sample)
        begin
            res_level_reg <= quot;
            res_key_reg   <= key_reg;
        end
        else if (cmd.write_load)
        begin
            res_level_reg <= lvl_reg;
            res_key_reg   <= key_reg;
        end
        else if (cmd.read_result)
        begin
            res_level_reg <= rd_level;
            res_key_reg   <= rd_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_hit_reg   <= '0;
            o_level_reg <= '0;
            o_key_reg   <= '0;
            o_cnt_reg   <= cnt_reg;
            unique case (cmd.kind)
                KIND_BAD_MODE:
                begin
                    o_outc_reg <= OUTC_DONE;
                    o_cnt_reg  <= '0;
                end
                KIND_BAD_ADDR:
                begin
                    o_outc_reg <= OUTC_DROPPED;
                    o_cnt_reg  <= '0;
                end
                KIND_FULL:
                begin
                    o_outc_reg <= OUTC_DROPPED;
                end
                KIND_DONE:
                begin
                    o_outc_reg <= OUTC_DONE;
                end
                KIND_MATCH, KIND_INSERT, KIND_ENTRY:
                begin
                    o_hit_reg   <= SLOT_FW'(k_reg);
                    o_level_reg <= res_level_reg;
                    o_key_reg   <= res_key_reg;
                    o_outc_reg  <= (cmd.kind == KIND_MATCH)  ? OUTC_MATCHED :
                                   (cmd.kind == KIND_INSERT) ? OUTC_INSERTED : OUTC_DONE;
                end
                default:
                begin
                    o_outc_reg <= OUTC_DONE;
                end
            endcase
        end
    end

    assign st.mode      = mode_reg;
    assign st.mode_bad  = (mode_reg > MODE_READ);
    assign st.addr_bad  = (int'(m_reg) >= MATRICES)
                        || ((mode_reg != MODE_CLOSE_SRV) && (int'(d_reg) >= DIRECTIONS))
                        || (((mode_reg == MODE_LOAD) || (mode_reg == MODE_READ))
                            && (int'(s_reg) >= SLOTS));
    assign st.clr_last  = (clr_reg == CLR_W'(ENTRIES - 1));
    assign st.last_slot = (k_reg == SLOT_W'(SLOTS - 1));
    assign st.key_hit   = (rd_key == key_reg);
    assign st.free_seen = free_seen_reg;
    assign st.div_done  = div_done;
    assign st.out_busy  = out_valid_reg && !result.ready;

    assign result.valid        = out_valid_reg;
    assign result.hit_slot     = o_hit_reg;
    assign result.outcome      = o_outc_reg;
    assign result.new_level    = o_level_reg;
    assign result.slot_key     = o_key_reg;
    assign result.survey_count = o_cnt_reg;

`ifndef ASSERT_OFF
    a_slot_in_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_sample || cmd.write_close || cmd.write_load) |-> (int'(k_reg) < SLOTS))
        else $error("entry write outside its direction");
`endif
endmodule
